@@ sv/aoi_pkg.sv @@
// aoi_pkg: shared constants, atan table and the cord_t fixed-point type for the odometry integrator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package aoi_pkg;

  typedef logic signed [33:0] cord_t;

  localparam int          PI_Q16       = 205887;
  localparam int          TWO_PI_Q16   = 411775;
  localparam longint      PI_Q30       = 64'sd3373259426;
  localparam longint      HALF_PI_Q30  = 64'sd1686629713;
  localparam longint      INV_GAIN_Q30 = 64'sd652032874;
  localparam longint      ONE_Q30      = 64'sd1073741824;
  localparam int          STEER_LIMIT  = 25735;
  localparam int          YAW_MAX      = 8388607;
  localparam int          WRAP_SHIFTS  = 9;
  localparam int          DIV_BITS     = 24;

  localparam logic [1:0]  REG_WHEELBASE = 2'd0;
  localparam logic [1:0]  REG_TIME_STEP = 2'd1;

  function automatic cord_t atan_q30(input logic [4:0] idx);
    cord_t r;
    case (idx)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd31: r = 34'sd0;
      default: r = cord_t'(34'sd1 <<< (5'd30 - idx));
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/aoi_if.sv @@
// aoi_cmd_if and aoi_pose_if: valid/ready channels for command and pose beats
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface aoi_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed;
  logic signed [15:0] steer_angle;
  modport source (output valid, output speed, output steer_angle, input ready);
  modport sink (input valid, input speed, input steer_angle, output ready);
endinterface

interface aoi_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_x;
  logic signed [31:0] position_y;
  logic signed [18:0] heading_out;
  logic signed [23:0] yaw_rate;
  modport source (output valid, output position_x, output position_y,
                  output heading_out, output yaw_rate, input ready);
  modport sink (input valid, input position_x, input position_y,
                input heading_out, input yaw_rate, output ready);
endinterface
`default_nettype wire

@@ sv/ackermann_odometry_integrator_core.sv @@
// ackermann_odometry_integrator_core: bicycle-model dead reckoning, one euler step per beat
// depends on aoi_pkg and the channel interfaces in aoi_if.sv
//
// usage:
//   in_cmd carries speed (Q4.12) and steer_angle (Q2.14); out_pose returns x, y (Q16.16),
//   heading (Q3.16) and yaw rate (Q12.12) for every command beat, in order.
//   cfg_we/cfg_index/cfg_wdata write wheelbase (index 0) and time step (index 1);
//   other indexes are ignored. write only while no beat is in flight.
//   one shared cordic rotator, run twice per beat (once with zero wheelbase), and a
//   restoring divider step sequenced by a one-hot state machine set the timing. the
//   next command can be taken, at the earliest, in the cycle in which out_pose.valid rises.
//   in_cmd.ready is high only while the sequencer is idle and no result waits for
//   the output register, so one beat is in work at a time; a finished result sits in
//   the output register and the next command can be taken while it waits. if the
//   receiver stalls, the following result waits in the pose registers and
//   in_cmd.ready stays low until the output register frees.
//   reset (synchronous, rst_n low) clears the pose to zero and loads wheelbase 1.5 m
//   and time step 0.05 s.
`timescale 1ns / 1ps
`default_nettype none
module ackermann_odometry_integrator_core
  import aoi_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  aoi_cmd_if.sink          in_cmd,
  aoi_pose_if.source       out_pose,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int ITER = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_YROT  = 13'b0000000000010,
    S_YMUL  = 13'b0000000000100,
    S_YCHK  = 13'b0000000001000,
    S_YDIV  = 13'b0000000010000,
    S_YSET  = 13'b0000000100000,
    S_HLOAD = 13'b0000001000000,
    S_HROT  = 13'b0000010000000,
    S_VT    = 13'b0000100000000,
    S_PX    = 13'b0001000000000,
    S_PY    = 13'b0010000000000,
    S_HSUM  = 13'b0100000000000,
    S_WRAP  = 13'b1000000000000
  } state_t;

  state_t             state_r;
  logic               out_pend_r;
  logic [15:0]        wheelbase_r;
  logic [15:0]        time_step_r;
  logic signed [31:0] pose_x_r;
  logic signed [31:0] pose_y_r;
  logic signed [18:0] heading_r;

  logic signed [15:0] v_r;
  cord_t              cx_r, cy_r, cz_r;
  logic [5:0]         cnt_r;
  logic               flip_r;
  logic               neg_r;
  logic               ovf_r;
  logic [47:0]        prod_r;
  logic [47:0]        den_r;
  logic [60:0]        rem_r;
  logic [70:0]        dsh_r;
  logic [23:0]        q_r;
  logic signed [23:0] yaw_r;
  cord_t              hc_r, hs_r;
  logic signed [32:0] vt_r;
  logic signed [66:0] px_r, py_r;
  logic signed [40:0] yd_r;
  logic [28:0]        u_r;

  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic signed [18:0] out_h_r;
  logic signed [23:0] out_yaw_r;

  // input clamp and steer cordic seed
  logic signed [15:0] phi_c;
  always_comb begin
    if (in_cmd.steer_angle > 16'sd25735) phi_c = 16'(STEER_LIMIT);
    else if (in_cmd.steer_angle < -16'sd25735) phi_c = -16'(STEER_LIMIT);
    else phi_c = in_cmd.steer_angle;
  end

  // shared cordic step
  logic [4:0] idx;
  logic       dir;
  cord_t      xs, ys, at, cx_step, cy_step, cz_step;
  always_comb begin
    idx = cnt_r[4:0];
    dir = !cz_r[33];
    xs = cx_r >>> idx;
    ys = cy_r >>> idx;
    at = atan_q30(idx);
    cx_step = dir ? cx_r - ys : cx_r + ys;
    cy_step = dir ? cy_r + xs : cy_r - xs;
    cz_step = dir ? cz_r - at : cz_r + at;
  end
  logic cord_last;
  assign cord_last = (cnt_r == 6'(ITER - 1));

  // yaw magnitude operands
  cord_t       c_cl, s_abs;
  logic [15:0] v_abs;
  always_comb begin
    c_cl  = (cx_r < 34'sd1) ? 34'sd1 : cx_r;
    s_abs = cy_r[33] ? -cy_r : cy_r;
    v_abs = v_r[15] ? 16'(-v_r) : v_r;
  end
  logic [60:0] n_val;
  assign n_val = {1'b0, prod_r, 12'b0} + 61'(den_r >> 1);
  logic        div_ge;
  assign div_ge = ({10'b0, rem_r} >= dsh_r);
  logic [22:0] q_sat;
  assign q_sat = (ovf_r || (q_r > 24'(YAW_MAX))) ? 23'(YAW_MAX) : q_r[22:0];

  // heading fold
  cord_t zh;
  always_comb begin
    zh = cord_t'($signed({heading_r, 14'b0}));
  end

  // pose update
  logic signed [66:0] rnd;
  logic signed [24:0] dx, dy;
  logic signed [33:0] sx, sy;
  logic signed [31:0] sat_x, sat_y;
  always_comb begin
    rnd = 67'sd1 <<< 41;
    dx = 25'((px_r + rnd) >>> 42);
    dy = 25'((py_r + rnd) >>> 42);
    sx = 34'(pose_x_r) + 34'(dx);
    sy = 34'(pose_y_r) + 34'(dy);
    if (sx > 34'sd2147483647) sat_x = 32'sh7fffffff;
    else if (sx < -34'sd2147483648) sat_x = 32'sh80000000;
    else sat_x = 32'(sx);
    if (sy > 34'sd2147483647) sat_y = 32'sh7fffffff;
    else if (sy < -34'sd2147483648) sat_y = 32'sh80000000;
    else sat_y = 32'(sy);
  end

  // heading wrap
  logic signed [29:0] dh;
  logic signed [31:0] u_full;
  logic [28:0]        wmod, u_step;
  always_comb begin
    dh = 30'((yd_r + 41'sd2048) >>> 12);
    u_full = 32'(heading_r) + 32'(dh) + 32'(PI_Q16) + 32'(TWO_PI_Q16 * 512);
    wmod = 29'(TWO_PI_Q16) << cnt_r[3:0];
    u_step = (u_r >= wmod) ? u_r - wmod : u_r;
  end

  assign in_cmd.ready = (state_r == S_IDLE) && !out_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wheelbase_r <= 16'd6144;
      time_step_r <= 16'd3277;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      heading_r   <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WHEELBASE: wheelbase_r <= cfg_wdata;
          REG_TIME_STEP: time_step_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_pend_r && (!out_valid_r || out_pose.ready)) begin
        out_valid_r <= 1'b1;
        out_pend_r  <= 1'b0;
        out_x_r     <= pose_x_r;
        out_y_r     <= pose_y_r;
        out_h_r     <= heading_r;
        out_yaw_r   <= yaw_r;
      end else if (out_valid_r && out_pose.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_cmd.valid && !out_pend_r) begin
            v_r   <= in_cmd.speed;
            cnt_r <= '0;
            if (wheelbase_r != 16'd0) begin
              cx_r    <= cord_t'(ONE_Q30);
              cy_r    <= '0;
              cz_r    <= cord_t'($signed({phi_c, 16'b0}));
              state_r <= S_YROT;
            end else begin
              yaw_r   <= '0;
              state_r <= S_HLOAD;
            end
          end
        end
        S_YROT: begin
          cx_r  <= cx_step;
          cy_r  <= cy_step;
          cz_r  <= cz_step;
          cnt_r <= cnt_r + 6'd1;
          if (cord_last) state_r <= S_YMUL;
        end
        S_YMUL: begin
          prod_r  <= 48'(v_abs) * 48'(s_abs[31:0]);
          den_r   <= 48'(wheelbase_r) * 48'(c_cl[31:0]);
          neg_r   <= v_r[15] != cy_r[33];
          state_r <= S_YCHK;
        end
        S_YCHK: begin
          rem_r   <= n_val;
          dsh_r   <= {den_r, 23'b0};
          ovf_r   <= ({11'b0, n_val} >= {den_r, 24'b0});
          q_r     <= '0;
          cnt_r   <= 6'(DIV_BITS - 1);
          state_r <= S_YDIV;
        end
        S_YDIV: begin
          if (div_ge) rem_r <= 61'({10'b0, rem_r} - dsh_r);
          q_r[idx] <= div_ge;
          dsh_r    <= dsh_r >> 1;
          cnt_r    <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) state_r <= S_YSET;
        end
        S_YSET: begin
          yaw_r   <= neg_r ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
          state_r <= S_HLOAD;
        end
        S_HLOAD: begin
          cx_r  <= cord_t'(INV_GAIN_Q30);
          cy_r  <= '0;
          cnt_r <= '0;
          if (zh > cord_t'(HALF_PI_Q30)) begin
            cz_r   <= zh - cord_t'(PI_Q30);
            flip_r <= 1'b1;
          end else if (zh < -cord_t'(HALF_PI_Q30)) begin
            cz_r   <= zh + cord_t'(PI_Q30);
            flip_r <= 1'b1;
          end else begin
            cz_r   <= zh;
            flip_r <= 1'b0;
          end
          state_r <= S_HROT;
        end
        S_HROT: begin
          cx_r  <= cx_step;
          cy_r  <= cy_step;
          cz_r  <= cz_step;
          cnt_r <= cnt_r + 6'd1;
          if (cord_last) state_r <= S_VT;
        end
        S_VT: begin
          hc_r    <= flip_r ? -cx_r : cx_r;
          hs_r    <= flip_r ? -cy_r : cy_r;
          vt_r    <= 33'(v_r) * $signed({17'b0, time_step_r});
          yd_r    <= 41'(yaw_r) * $signed({25'b0, time_step_r});
          state_r <= S_PX;
        end
        S_PX: begin
          px_r    <= 67'(vt_r) * 67'(hc_r);
          py_r    <= 67'(vt_r) * 67'(hs_r);
          state_r <= S_PY;
        end
        S_PY: begin
          pose_x_r <= sat_x;
          pose_y_r <= sat_y;
          state_r  <= S_HSUM;
        end
        S_HSUM: begin
          u_r     <= u_full[28:0];
          cnt_r   <= 6'(WRAP_SHIFTS);
          state_r <= S_WRAP;
        end
        S_WRAP: begin
          u_r   <= u_step;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            heading_r  <= 19'($signed({1'b0, u_step}) - 30'(PI_Q16));
            out_pend_r <= 1'b1;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_pose.valid       = out_valid_r;
  assign out_pose.position_x  = out_x_r;
  assign out_pose.position_y  = out_y_r;
  assign out_pose.heading_out = out_h_r;
  assign out_pose.yaw_rate    = out_yaw_r;

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_cmd.valid && in_cmd.ready && !out_pend_r) |=> !in_cmd.ready)
    else $error("command accepted while a beat is in work");
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (heading_r <= 19'sd205887) && (heading_r >= -19'sd205887))
    else $error("heading left the wrapped range");
  a_div_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_YDIV) |-> (den_r != 48'd0))
    else $error("divide with zero divisor");
  a_no_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pose.ready) |=> out_valid_r)
    else $error("result dropped while stalled");

endmodule
`default_nettype wire

@@ bench/tb_ackermann_odometry_integrator_core.sv @@
// tb_ackermann_odometry_integrator_core: self-checking bench for the bicycle-model odometry core
// depends on aoi_pkg, aoi_if.sv and ackermann_odometry_integrator_core
// predicts each pose beat with a bit-true fixed-point model and compares fields in order
`timescale 1ns / 1ps
module tb_ackermann_odometry_integrator_core
  import aoi_pkg::*;
;

  localparam int N_ITER = 16;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [18:0] hd;
    logic signed [23:0] yaw;
  } pose_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  aoi_cmd_if cmd ();
  aoi_pose_if pose ();

  ackermann_odometry_integrator_core #(.CORDIC_STEPS(N_ITER)) dut (
    .clk(clk), .rst_n(rst_n), .in_cmd(cmd.sink), .out_pose(pose.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor state
  longint wb_q12, dt_q16, odo_x, odo_y, odo_h;
  pose_t pose_q[$];
  int errors = 0;
  int cycle = 0;
  bit idle_en = 1;
  bit hold_rx = 0;

  longint atan_tab[32] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic void rotate(longint z, longint x0, output longint c, output longint s);
    longint x, y, xs, ys;
    x = x0;
    y = 0;
    for (int i = 0; i < N_ITER; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic integrate_step(input logic signed [15:0] spd, input logic signed [15:0] st);
    longint v, phi, yaw, z, hc, hs, c, s, dx, dy, h, t, q;
    logic [127:0] num, den;
    bit flip, neg;
    pose_t p;
    v = spd;
    phi = st;
    yaw = 0;
    flip = 0;
    if (phi > STEER_LIMIT) phi = STEER_LIMIT;
    if (phi < -STEER_LIMIT) phi = -STEER_LIMIT;
    if (wb_q12 != 0) begin
      rotate(phi * 65536, ONE_Q30, c, s);
      if (c < 1) c = 1;
      neg = (v < 0) != (s < 0);
      num = 128'(v < 0 ? -v : v) * 128'(s < 0 ? -s : s) * 4096;
      den = 128'(wb_q12) * 128'(c);
      q = longint'((num + den / 2) / den);
      if ((num + den / 2) / den > YAW_MAX) q = YAW_MAX;
      yaw = neg ? -q : q;
    end
    z = odo_h * 16384;
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30; flip = 1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30; flip = 1;
    end
    rotate(z, INV_GAIN_Q30, hc, hs);
    if (flip) begin
      hc = -hc; hs = -hs;
    end
    dx = (v * hc * dt_q16 + (64'sd1 <<< 41)) >>> 42;
    dy = (v * hs * dt_q16 + (64'sd1 <<< 41)) >>> 42;
    odo_x = sat32(odo_x + dx);
    odo_y = sat32(odo_y + dy);
    h = odo_h + ((yaw * dt_q16 + 2048) >>> 12);
    t = (h + PI_Q16) % TWO_PI_Q16;
    if (t < 0) t += TWO_PI_Q16;
    odo_h = t - PI_Q16;
    p.px = odo_x[31:0];
    p.py = odo_y[31:0];
    p.hd = odo_h[18:0];
    p.yaw = yaw[23:0];
    pose_q = {pose_q, p};
  endtask

  // valid stays high after a beat until the next one is offered or the sender idles
  task automatic send_cmd(input logic signed [15:0] spd, input logic signed [15:0] st);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      cmd.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1;
    cmd.speed <= spd;
    cmd.steer_angle <= st;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    integrate_step(spd, st);
  endtask

  task automatic drain();
    cmd.valid <= 0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_WHEELBASE) wb_q12 = val;
    else if (idx == REG_TIME_STEP) dt_q16 = val;
  endtask

  // receiver: random stalls, plus a long hold when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      pose.ready <= 0;
    end else if (hold_rx) begin
      pose.ready <= 0;
    end else if (idle_en && pose.ready && $urandom_range(0, 7) == 0) begin
      pose.ready <= 0;
    end else if (!pose.ready && idle_en && $urandom_range(0, 3) != 0) begin
      pose.ready <= 0;
    end else begin
      pose.ready <= 1;
    end
  end

  // checker
  always @(posedge clk) begin
    pose_t e;
    cycle <= cycle + 1;
    if (rst_n && pose.valid && pose.ready) begin
      if (pose_q.size() == 0) begin
        $display("%0t unexpected beat x=%0d", $time, pose.position_x);
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (pose.position_x !== e.px) begin
          $display("%0t position_x exp %0d got %0d", $time, e.px, pose.position_x);
          errors++;
        end
        if (pose.position_y !== e.py) begin
          $display("%0t position_y exp %0d got %0d", $time, e.py, pose.position_y);
          errors++;
        end
        if (pose.heading_out !== e.hd) begin
          $display("%0t heading exp %0d got %0d", $time, e.hd, pose.heading_out);
          errors++;
        end
        if (pose.yaw_rate !== e.yaw) begin
          $display("%0t yaw_rate exp %0d got %0d", $time, e.yaw, pose.yaw_rate);
          errors++;
        end
      end
    end
    if (cycle > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    logic signed [15:0] spds[6] = '{16'sh7FFF, -16'sh8000, 0, 4096, -4096, 1};
    logic signed [15:0] steers[7] = '{0, 25735, -25735, 16'sh7FFF, -16'sh8000, 25734, 100};
    for (int i = 0; i < 6; i++) send_cmd(spds[i], steers[i]);
    for (int i = 0; i < 7; i++) send_cmd(16'sh4000, steers[i]);
    drain();
  endtask

  task automatic test_config_sweep();
    logic [15:0] wbs[4] = '{0, 1, 16'hFFFF, 6144};
    logic [15:0] dts[4] = '{16'hFFFF, 0, 1, 3277};
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_WHEELBASE, wbs[k]);
      write_reg(REG_TIME_STEP, dts[k]);
      write_reg(2'd3, 16'hA5A5);
      for (int i = 0; i < 8; i++)
        send_cmd(16'($urandom), 16'($urandom_range(0, 51470) - 25735));
      drain();
    end
  endtask

  task automatic test_random(input int n);
    logic signed [15:0] st;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) st = 16'($urandom);
      else st = 16'($urandom_range(0, 51470) - 25735);
      send_cmd(16'($urandom), st);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1;
        repeat (600) @(posedge clk);
        hold_rx = 0;
      end
      test_random(12);
    join
    drain();
  endtask

  initial begin
    cmd.valid <= 0;
    cmd.speed <= 0;
    cmd.steer_angle <= 0;
    wb_q12 = 6144;
    dt_q16 = 3277;
    odo_x = 0;
    odo_y = 0;
    odo_h = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    write_reg(REG_WHEELBASE, 16'($urandom_range(1024, 12000)));
    write_reg(REG_TIME_STEP, 16'($urandom_range(1000, 30000)));
    test_random(400);
    drain();
    test_backpressure();
    idle_en = 0;
    test_random(60);
    drain();
    if (errors == 0 && pose_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
